[src/clf_pkg.sv]
`timescale 1ns / 1ps
// Console line formatter: shared types and constants.
// No dependencies; imported by every module of the block.
package clf_pkg;

  localparam int CNT_W = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic REG_LINE_COLUMNS = 1'b0;
  localparam logic REG_TAB_WIDTH    = 1'b1;

  // control characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef enum logic [3:0] {
    OP_FLUSH,
    OP_NEWLINE,
    OP_ALARM,
    OP_TAB,
    OP_FORMFEED,
    OP_BACKSPACE,
    OP_NUL,
    OP_PRINT,
    OP_IGNORE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    K_WRITE  = 3'd0,
    K_FILL   = 3'd1,
    K_END    = 3'd2,
    K_ALARM  = 3'd3,
    K_NOROOM = 3'd4,
    K_READY  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       column;
    logic [7:0]       payload;
    logic [7:0]       closed_length;
    logic [CNT_W-1:0] lines_buffered;
    logic [CNT_W-1:0] chars_buffered;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE_CLOSE,
    S_OPEN,
    S_DIV,
    S_ACT,
    S_CHECK,
    S_READY,
    S_EMIT
  } back_state_t;

endpackage

[src/console_line_formatter_top.sv]
`timescale 1ns / 1ps
// Console line formatter top level: configuration registers, front end,
// command queue and back end. Uses clf_pkg, clf_front, clf_queue, clf_back.
//
// Console characters (or a flush request) come in on the slave stream and
// leave as line-building commands on the master stream, zero to three per
// item, the last one flagged by tlast. The front end takes one item per
// cycle, while the queue has room, into a four-entry command queue; the
// back end sequencer sets the pace: it fetches a command, runs its
// close/open/act steps, then a check step (a buffer-ready step for a flush,
// none when a line cannot be opened for lack of room), then hands each
// result to the output register while it is not stalled and finishes. A tab
// adds a bit-serial remainder step against the tab width. Configuration
// writes must be made only while the block is idle; the block itself does
// not enforce this.
module console_line_formatter_top import clf_pkg::*; #(
  parameter int BUFFER_ROOM       = 4000,
  parameter int LINE_HEADER_BYTES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] operation
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] column, [15:8] payload, [23:16] closed_length,
                                      // [36:24] lines_buffered, [49:37] chars_buffered
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last
);

  logic [7:0] line_columns;
  logic [7:0] tab_width;
  logic       push;
  cmd_t       push_cmd;
  logic       q_ready;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_cmd;
  res_t       out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_columns <= 8'd80;
      tab_width    <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_COLUMNS: line_columns <= cfg_data;
        REG_TAB_WIDTH:    tab_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  clf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .operation   (s_axis_tuser),
    .char_code   (s_axis_tdata),
    .message_end (s_axis_tlast),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_ready     (q_ready)
  );

  clf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  clf_back #(
    .BUFFER_ROOM       (BUFFER_ROOM),
    .LINE_HEADER_BYTES (LINE_HEADER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .line_columns (line_columns),
    .tab_width    (tab_width),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_res      (out_res),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_res.chars_buffered, out_res.lines_buffered,
                         out_res.closed_length, out_res.payload, out_res.column};
  assign m_axis_tuser = out_res.kind;

endmodule

[src/clf_front.sv]
`timescale 1ns / 1ps
// Console line formatter front end: takes input items, tracks message skipping
// after NUL and classifies each character into a command. Uses clf_pkg.
module clf_front import clf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] char_code,
  input  logic       message_end,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_ready
);

  logic    skipping;
  logic    skipping_next;
  logic    accept;
  cmd_op_t char_op;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    char_op = OP_IGNORE;
    unique case (char_code)
      CH_NUL: char_op = OP_NUL;
      CH_BEL: char_op = OP_ALARM;
      CH_BS:  char_op = OP_BACKSPACE;
      CH_TAB: char_op = OP_TAB;
      CH_LF:  char_op = OP_NEWLINE;
      CH_VT:  char_op = OP_FORMFEED;
      CH_FF:  char_op = OP_FORMFEED;
      default: begin
        if ((char_code >= 8'h20 && char_code <= 8'h7E) || char_code >= 8'hA0) begin
          char_op = OP_PRINT;
        end
      end
    endcase
  end

  always_comb begin
    push_cmd.op   = operation ? OP_FLUSH : char_op;
    push_cmd.ch   = char_code;
    push          = accept && (operation || !skipping);
    skipping_next = skipping;
    if (accept && !operation) begin
      if (skipping) begin
        if (message_end) begin
          skipping_next = 1'b0;
        end
      end else if (char_op == OP_NUL) begin
        skipping_next = !message_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skipping <= 1'b0;
    end else begin
      skipping <= skipping_next;
    end
  end

endmodule

[src/clf_queue.sv]
`timescale 1ns / 1ps
// Console line formatter command queue: a short register FIFO between the
// front and back ends. Uses clf_pkg.
module clf_queue import clf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/clf_back.sv]
`timescale 1ns / 1ps
// Console line formatter back end: sequences each command over line state and
// buffer counters, collects its results and drives the output register. Uses clf_pkg.
module clf_back import clf_pkg::*; #(
  parameter int BUFFER_ROOM       = 4000,
  parameter int LINE_HEADER_BYTES = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] line_columns,
  input  logic [7:0] tab_width,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res,
  output logic       out_last
);

  localparam int SUM_W = 15;

  back_state_t      state, state_next;
  cmd_t             cmd, cmd_next;
  logic             line_open, line_open_next;
  logic [7:0]       line_len, line_len_next;
  logic [CNT_W-1:0] used, used_next;
  logic [CNT_W-1:0] lines, lines_next;
  logic [CNT_W-1:0] chars, chars_next;
  logic [7:0]       spaces, spaces_next;
  logic             ff_open, ff_open_next;
  logic [7:0]       rem, rem_next;
  logic [7:0]       dvd, dvd_next;
  logic [2:0]       div_cnt, div_cnt_next;
  res_t             res [3];
  res_t             res_next [3];
  logic [1:0]       res_cnt, res_cnt_next;
  logic [1:0]       emit_idx, emit_idx_next;
  logic             out_valid_next;
  res_t             out_res_next;
  logic             out_last_next;

  logic             do_close;
  logic             emit_en;
  res_t             emit_item;
  logic [7:0]       tw_eff;
  logic [7:0]       reserve;
  logic [SUM_W-1:0] room_need;
  logic             no_room;
  logic [SUM_W-1:0] close_sum;
  logic [CNT_W:0]   chars_sum;
  logic [8:0]       div_trial;
  logic [8:0]       tab_target;
  logic [7:0]       tab_len;

  assign tw_eff    = (tab_width == 8'd0) ? 8'd1 : tab_width;
  assign reserve   = (cmd.op == OP_NEWLINE) ? 8'd0 : line_columns;
  assign room_need = SUM_W'(used) + SUM_W'(LINE_HEADER_BYTES) + SUM_W'(reserve);
  assign no_room   = room_need > SUM_W'(BUFFER_ROOM);
  assign close_sum = SUM_W'(used) + SUM_W'(LINE_HEADER_BYTES) + SUM_W'(line_len);
  assign chars_sum = (CNT_W + 1)'(chars) + (CNT_W + 1)'(line_len);
  assign div_trial = {rem, dvd[7]};
  assign tab_target = {1'b0, line_len} - {1'b0, rem} + {1'b0, tw_eff};
  assign tab_len    = (tab_target > {1'b0, line_columns}) ? line_columns : tab_target[7:0];

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    line_open_next = line_open;
    line_len_next  = line_len;
    used_next      = used;
    lines_next     = lines;
    chars_next     = chars;
    spaces_next    = spaces;
    ff_open_next   = ff_open;
    rem_next       = rem;
    dvd_next       = dvd;
    div_cnt_next   = div_cnt;
    res_next       = res;
    res_cnt_next   = res_cnt;
    emit_idx_next  = emit_idx;
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;
    out_last_next  = out_last;
    q_pop          = 1'b0;
    do_close       = 1'b0;
    emit_en        = 1'b0;
    emit_item      = '0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cmd_next      = q_cmd;
          res_cnt_next  = '0;
          emit_idx_next = '0;
          spaces_next   = line_len;
          ff_open_next  = line_open;
          dvd_next      = line_len;
          rem_next      = '0;
          div_cnt_next  = '0;
          case (q_cmd.op) inside
            OP_FLUSH, OP_NUL: state_next = S_PRE_CLOSE;
            OP_FORMFEED:      state_next = line_open ? S_PRE_CLOSE : S_OPEN;
            OP_NEWLINE, OP_PRINT: state_next = line_open ? S_ACT : S_OPEN;
            OP_TAB:           state_next = line_open ? S_DIV : S_OPEN;
            default:          state_next = S_ACT;
          endcase
        end
      end
      S_PRE_CLOSE: begin
        do_close = line_open;
        if (cmd.op == OP_FLUSH) begin
          state_next = S_READY;
        end else if (cmd.op == OP_FORMFEED) begin
          state_next = S_OPEN;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_OPEN: begin
        if (no_room) begin
          emit_en        = 1'b1;
          emit_item.kind = K_NOROOM;
          state_next     = S_EMIT;
        end else begin
          line_open_next = 1'b1;
          line_len_next  = '0;
          dvd_next       = '0;
          rem_next       = '0;
          div_cnt_next   = '0;
          state_next     = (cmd.op == OP_TAB) ? S_DIV : S_ACT;
        end
      end
      S_DIV: begin
        // one remainder bit per cycle, line length modulo tab width
        if (div_trial >= {1'b0, tw_eff}) begin
          rem_next = 8'(div_trial - {1'b0, tw_eff});
        end else begin
          rem_next = div_trial[7:0];
        end
        dvd_next     = {dvd[6:0], 1'b0};
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == 3'd7) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        case (cmd.op)
          OP_NEWLINE: do_close = 1'b1;
          OP_ALARM: begin
            emit_en        = 1'b1;
            emit_item.kind = K_ALARM;
          end
          OP_TAB: begin
            if (line_len < line_columns) begin
              emit_en           = 1'b1;
              emit_item.kind    = K_FILL;
              emit_item.column  = line_len;
              emit_item.payload = tab_len - line_len;
              line_len_next     = tab_len;
            end
          end
          OP_FORMFEED: begin
            if (ff_open) begin
              if (spaces != 8'd0) begin
                emit_en           = 1'b1;
                emit_item.kind    = K_FILL;
                emit_item.payload = spaces;
              end
              line_len_next = spaces;
            end else begin
              do_close = 1'b1;
            end
          end
          OP_BACKSPACE: begin
            if (line_open && line_len != 8'd0) begin
              line_len_next = line_len - 1'b1;
            end
          end
          OP_PRINT: begin
            emit_en           = 1'b1;
            emit_item.kind    = K_WRITE;
            emit_item.column  = line_len;
            emit_item.payload = cmd.ch;
            if (line_len != 8'hFF) begin
              line_len_next = line_len + 1'b1;
            end
          end
          default: ;
        endcase
        state_next = S_CHECK;
      end
      S_CHECK: begin
        do_close   = line_open && (line_len >= line_columns);
        state_next = S_EMIT;
      end
      S_READY: begin
        if (lines != '0) begin
          emit_en                  = 1'b1;
          emit_item.kind           = K_READY;
          emit_item.lines_buffered = lines;
          emit_item.chars_buffered = chars;
          used_next                = '0;
          lines_next               = '0;
          chars_next               = '0;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_idx == res_cnt) begin
          state_next = S_IDLE;
        end else if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_res_next   = res[emit_idx];
          out_last_next  = (emit_idx == res_cnt - 1'b1);
          emit_idx_next  = emit_idx + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (do_close) begin
      emit_en                 = 1'b1;
      emit_item.kind          = K_END;
      emit_item.closed_length = line_len;
      used_next  = (close_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : close_sum[CNT_W-1:0];
      lines_next = (lines == CNT_MAX) ? lines : lines + 1'b1;
      chars_next = (chars_sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_MAX : chars_sum[CNT_W-1:0];
      line_open_next = 1'b0;
      line_len_next  = '0;
    end

    if (emit_en) begin
      res_next[res_cnt] = emit_item;
      res_cnt_next      = res_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      line_open <= 1'b0;
      line_len  <= '0;
      used      <= '0;
      lines     <= '0;
      chars     <= '0;
      res_cnt   <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      line_open <= line_open_next;
      line_len  <= line_len_next;
      used      <= used_next;
      lines     <= lines_next;
      chars     <= chars_next;
      res_cnt   <= res_cnt_next;
      emit_idx  <= emit_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    spaces   <= spaces_next;
    ff_open  <= ff_open_next;
    rem      <= rem_next;
    dvd      <= dvd_next;
    div_cnt  <= div_cnt_next;
    res      <= res_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
  end

endmodule

[src/clf_checker.sv]
`timescale 1ns / 1ps
// Console line formatter port checker and its bind to the top level.
// Uses clf_pkg; sees the top level ports only.
module clf_port_checks import clf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == K_READY |-> m_axis_tdata[36:24] != 13'd0 && m_axis_tlast)
    else $error("buffer ready with no lines or not last");

  a_write_printable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == K_WRITE |->
      (m_axis_tdata[15:8] >= 8'h20 && m_axis_tdata[15:8] <= 8'h7E) || m_axis_tdata[15:8] >= 8'hA0)
    else $error("write of an unprintable byte");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == K_FILL |-> m_axis_tdata[15:8] != 8'd0)
    else $error("fill with zero blanks");

endmodule

bind console_line_formatter_top clf_port_checks u_clf_port_checks (.*);
